>>> src/bls_pkg.sv
// shared types and constants for the boot loop safe mode tracker
package bls_pkg;

    localparam int STREAK_W  = 8;
    localparam int COUNT_W   = 32;
    localparam int REASON_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 56;

    localparam logic [STREAK_W-1:0] STREAK_MAX        = 8'd255;
    localparam logic [STREAK_W-1:0] THRESHOLD_DEFAULT = 8'd3;
    localparam logic [COUNT_W-1:0]  CLEAN_DEFAULT     = 32'd600000;
    localparam logic [COUNT_W-1:0]  UPTIME_MAX        = 32'hFFFF_FFFF;

    typedef enum logic {
        ACT_BOOT = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAFE_THRESHOLD = 1'b0,
        REG_CLEAN_UPTIME   = 1'b1
    } t_reg_index;

    localparam logic [REASON_W-1:0] RST_UNKNOWN   = 4'd0;
    localparam logic [REASON_W-1:0] RST_POWERON   = 4'd1;
    localparam logic [REASON_W-1:0] RST_EXT       = 4'd2;
    localparam logic [REASON_W-1:0] RST_SW        = 4'd3;
    localparam logic [REASON_W-1:0] RST_PANIC     = 4'd4;
    localparam logic [REASON_W-1:0] RST_INT_WDT   = 4'd5;
    localparam logic [REASON_W-1:0] RST_TASK_WDT  = 4'd6;
    localparam logic [REASON_W-1:0] RST_WDT       = 4'd7;
    localparam logic [REASON_W-1:0] RST_DEEPSLEEP = 4'd8;
    localparam logic [REASON_W-1:0] RST_BROWNOUT  = 4'd9;
    localparam logic [REASON_W-1:0] RST_SDIO      = 4'd10;

    typedef struct packed {
        logic                cleared_now;
        logic [COUNT_W-1:0]  total_boots;
        logic [STREAK_W-1:0] brownout_count;
        logic [STREAK_W-1:0] abnormal_count;
        logic                safe_on;
    } t_result;

    function automatic logic reason_is_abnormal(input logic [REASON_W-1:0] r);
        return (r == RST_PANIC) || (r == RST_INT_WDT) || (r == RST_TASK_WDT) ||
               (r == RST_WDT) || (r == RST_BROWNOUT);
    endfunction

    function automatic logic [STREAK_W-1:0] sat_inc(input logic [STREAK_W-1:0] v);
        return (v == STREAK_MAX) ? STREAK_MAX : v + 1'b1;
    endfunction

endpackage

>>> src/bls_core.sv
// tracker state and its per-event update
module bls_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_action,
    input  logic [bls_pkg::REASON_W-1:0]  i_reason,
    input  logic [bls_pkg::STREAK_W-1:0]  i_threshold,
    input  logic [bls_pkg::COUNT_W-1:0]   i_clean_ticks,
    output bls_pkg::t_result              o_result
);
    import bls_pkg::*;

    logic [STREAK_W-1:0] r_abn, n_abn;
    logic [STREAK_W-1:0] r_brn, n_brn;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic [COUNT_W-1:0]  r_up, n_up;
    logic                r_clr_done, n_clr_done;
    logic                r_safe, n_safe;
    logic                cleared;

    always_comb begin
        n_abn      = r_abn;
        n_brn      = r_brn;
        n_total    = r_total;
        n_up       = r_up;
        n_clr_done = r_clr_done;
        n_safe     = r_safe;
        cleared    = 1'b0;
        if (t_action'(i_action) == ACT_BOOT) begin
            n_total = r_total + 1'b1;
            if (reason_is_abnormal(i_reason)) begin
                n_abn = sat_inc(r_abn);
            end else if (i_reason == RST_POWERON) begin
                n_abn = '0;
            end
            if (i_reason == RST_BROWNOUT) begin
                n_brn = sat_inc(r_brn);
            end else if (i_reason == RST_POWERON) begin
                n_brn = '0;
            end
            n_safe     = (n_abn >= i_threshold);
            n_up       = '0;
            n_clr_done = 1'b0;
        end else begin
            if (r_up != UPTIME_MAX) begin
                n_up = r_up + 1'b1;
            end
            // one clean clear per boot, only when there is a streak to clear
            if (!r_clr_done && (r_abn != '0 || r_brn != '0) && n_up >= i_clean_ticks) begin
                n_abn      = '0;
                n_brn      = '0;
                n_clr_done = 1'b1;
                cleared    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abn      <= '0;
            r_brn      <= '0;
            r_total    <= '0;
            r_up       <= '0;
            r_clr_done <= 1'b0;
            r_safe     <= 1'b0;
        end else if (i_fire) begin
            r_abn      <= n_abn;
            r_brn      <= n_brn;
            r_total    <= n_total;
            r_up       <= n_up;
            r_clr_done <= n_clr_done;
            r_safe     <= n_safe;
        end
    end

    assign o_result.safe_on        = n_safe;
    assign o_result.abnormal_count = n_abn;
    assign o_result.brownout_count = n_brn;
    assign o_result.total_boots    = n_total;
    assign o_result.cleared_now    = cleared;

endmodule

>>> src/boot_loop_safe_mode_tracker.sv
// top level of the boot loop safe mode tracker
//
//  channel   dir  handshake            payload
//  s_*       in   tvalid/tready        tdata: reset_reason; tuser: action
//  m_*       out  tvalid/tready        tdata: safe_on..cleared_now
//  cfg_*     in   we                   index, data
//
// one beat per cycle while the output is not stalled; a result appears in the cycle after its input beat.
// state update and result come from short combinational logic between the
// accepted beat and the result register.
// reset clears the streaks, the counters and the output valid.
// input ready stays high while the result register is empty or being taken.
module boot_loop_safe_mode_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bls_pkg::S_DATA_W-1:0]    i_s_tdata,  // [3:0] reset_reason, [7:4] zero
    input  logic                            i_s_tuser,  // [0] action
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] safe_on, [8:1] abnormal_count, [16:9] brownout_count,
    // [48:17] total_boots, [49] cleared_now, [55:50] zero
    output logic [bls_pkg::M_DATA_W-1:0]    o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bls_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import bls_pkg::*;

    logic [STREAK_W-1:0] r_threshold;
    logic [COUNT_W-1:0]  r_clean_ticks;
    logic                r_out_valid;
    t_result             r_out;
    t_result             result;
    logic                fire;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign fire       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_DEFAULT;
            r_clean_ticks <= CLEAN_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_SAFE_THRESHOLD: r_threshold   <= i_cfg_data[STREAK_W-1:0];
                REG_CLEAN_UPTIME:   r_clean_ticks <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    bls_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_action      (i_s_tuser),
        .i_reason      (i_s_tdata[REASON_W-1:0]),
        .i_threshold   (r_threshold),
        .i_clean_ticks (r_clean_ticks),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

>>> src/bls_checker.sv
// port-level checks for the boot loop safe mode tracker
module bls_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            o_s_tready,
    input  logic                            i_s_tuser,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [bls_pkg::M_DATA_W-1:0]    o_m_tdata
);
    import bls_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // every input beat shows up as a result next cycle
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted beat gave no result");

    // a clean clear leaves both streaks at zero and happens only on a tick
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> !o_m_tdata[49])
        else $error("clear flagged on a boot beat");

    a_clear_streaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[49] |-> o_m_tdata[16:1] == '0)
        else $error("clear left a streak nonzero");

endmodule

bind boot_loop_safe_mode_tracker bls_checker u_bls_checker (.*);
